FILE: src/btrt_pkg.sv
// ----------------------------------------------------------------------------
// btrt_pkg
// Shared types and constants for the binary trie route table.
// ----------------------------------------------------------------------------
package btrt_pkg;

  localparam int ADDR_BITS = 32;
  localparam int ABW       = 5;   // bit index width inside an address
  localparam int LEN_W     = 6;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_REJECT   = 2'd1;
  localparam logic [1:0] STAT_NOTFOUND = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  typedef enum logic [1:0] {
    CMD_INSERT,
    CMD_DELETE,
    CMD_LOOKUP,
    CMD_REJECT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e              kind;
    logic [ADDR_BITS-1:0]   address;
    logic [LEN_W-1:0]       prefix_len;
    logic [31:0]            gateway;
  } btrt_cmd_t;

  typedef struct packed {
    logic      valid;
    btrt_cmd_t cmd;
  } btrt_queue_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_EX,
    S_POP,
    S_POPW,
    S_FREE,
    S_GW,
    S_DONE
  } eng_state_e;

endpackage

FILE: src/binary_trie_route_table.sv
// ----------------------------------------------------------------------------
// binary_trie_route_table
// IPv4 longest prefix match route table kept as a one-bit-per-level trie.
// ----------------------------------------------------------------------------
// Requests go into a two-entry queue and are carried out one at a time by a
// walker on a node memory with registered read, with a read and an execute
// state per trie level. A lookup visits up to 33 levels, then reads the
// gateway of the longest match if any. Insert and delete walk the path first
// to check it and, if that passes, again to update it. Insert adds a pop step
// per newly allocated node, delete a free step per freed node. A rejected
// request goes straight to the result. After reset the node memory and free
// list are initialized in a pass over all NODES entries, during which
// requests only fill the queue. One result is returned per request, in order.
module binary_trie_route_table #(
  parameter int NODES = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 op_i,
  input  logic [31:0]                address_i,
  input  logic [5:0]                 prefix_len_i,
  input  logic [31:0]                gateway_in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [31:0]                gateway_out_o,
  output logic [5:0]                 match_len_o
);
  import btrt_pkg::*;

  btrt_queue_t queue;
  logic        pop;

  btrt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .address_i    (address_i),
    .prefix_len_i (prefix_len_i),
    .gateway_in_i (gateway_in_i),
    .queue_o      (queue),
    .pop_i        (pop)
  );

  btrt_engine #(
    .NODES (NODES)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_i       (queue),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .gateway_out_o (gateway_out_o),
    .match_len_o   (match_len_o)
  );

  a_pop_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> queue.valid)
    else $error("queue popped while empty");

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_OK |-> gateway_out_o == '0 && match_len_o == '0)
    else $error("failed request carries match data");

  a_len_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> match_len_o <= 6'(ADDR_BITS))
    else $error("match length out of range");

endmodule

FILE: src/btrt_front.sv
// ----------------------------------------------------------------------------
// btrt_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module btrt_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                op_i,
  input  logic [btrt_pkg::ADDR_BITS-1:0] address_i,
  input  logic [btrt_pkg::LEN_W-1:0] prefix_len_i,
  input  logic [31:0]               gateway_in_i,
  output btrt_pkg::btrt_queue_t     queue_o,
  input  logic                      pop_i
);
  import btrt_pkg::*;

  btrt_cmd_t  entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push;
  logic       req_ok;
  btrt_cmd_t  cmd;

  always_comb begin
    req_ok = (address_i != '0) && (prefix_len_i != '0)
             && (prefix_len_i <= LEN_W'(ADDR_BITS));
    cmd.address    = address_i;
    cmd.prefix_len = prefix_len_i;
    cmd.gateway    = gateway_in_i;
    case (op_i)
      OP_INSERT: cmd.kind = req_ok ? CMD_INSERT : CMD_REJECT;
      OP_DELETE: cmd.kind = req_ok ? CMD_DELETE : CMD_REJECT;
      OP_LOOKUP: cmd.kind = CMD_LOOKUP;
      default:   cmd.kind = CMD_REJECT;
    endcase
  end

  assign in_stall_o    = count_q[1];
  assign push          = in_valid_i && !in_stall_o;
  assign queue_o.valid = count_q != 2'd0;
  assign queue_o.cmd   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(pop_i);
    end
  end

endmodule

FILE: src/btrt_engine.sv
// ----------------------------------------------------------------------------
// btrt_engine
// Walks the trie one level at a time, a read and an execute state per level,
// to insert, delete and look up routes, and holds the result register.
// ----------------------------------------------------------------------------
module btrt_engine #(
  parameter int NODES = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  btrt_pkg::btrt_queue_t      queue_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [31:0]                gateway_out_o,
  output logic [btrt_pkg::LEN_W-1:0] match_len_o
);
  import btrt_pkg::*;

  localparam int IW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);
  localparam int W  = 2 * IW + 1 + CW;

  // node word: {child1, child0, end mark, pass count}
  logic [W-1:0]  node_mem [NODES];
  logic [IW-1:0] stk_mem  [NODES];
  logic [31:0]   gw_mem   [NODES];

  logic          node_we;
  logic [IW-1:0] node_waddr, node_raddr;
  logic [W-1:0]  node_wdata, node_rd_q;
  logic          stk_we;
  logic [IW-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rd_q;
  logic          gw_we;
  logic [IW-1:0] gw_waddr, gw_raddr;
  logic [31:0]   gw_rd_q;

  eng_state_e state_q, state_d;
  btrt_cmd_t  cmd_q, cmd_d;
  logic [IW-1:0]    cur_q, cur_d, par_q, par_d, best_q, best_d, clr_q, clr_d;
  logic [LEN_W-1:0] lvl_q, lvl_d, bestlen_q, bestlen_d;
  logic             pass2_q, pass2_d, fresh_q, fresh_d, found_q, found_d;
  logic             pb_q, pb_d;
  logic [W-1:0]     wb_q, wb_d, parw_q, parw_d;
  logic [CW-1:0]    top_q, top_d;
  logic [1:0]       res_st_q, res_st_d;
  logic [31:0]      res_gw_q, res_gw_d;
  logic [LEN_W-1:0] res_len_q, res_len_d;
  logic             ov_q, ov_d;
  logic [1:0]       ost_q, ost_d;
  logic [31:0]      ogw_q, ogw_d;
  logic [LEN_W-1:0] olen_q, olen_d;

  logic [W-1:0]     word, nw;
  logic [IW-1:0]    c0, c1, nx, wb_nx;
  logic             mk, b, at_end;
  logic [CW-1:0]    cnt, new_cnt;
  logic [ABW-1:0]   bidx;
  logic [LEN_W-1:0] need;

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_rd_q <= node_mem[node_raddr];
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_q <= stk_mem[stk_raddr];
    if (gw_we) begin
      gw_mem[gw_waddr] <= cmd_q.gateway;
    end
    gw_rd_q <= gw_mem[gw_raddr];
  end

  always_comb begin
    word    = fresh_q ? '0 : node_rd_q;
    cnt     = word[CW-1:0];
    mk      = word[CW];
    c0      = word[CW+IW:CW+1];
    c1      = word[W-1:CW+IW+1];
    bidx    = ABW'(ADDR_BITS - 1) - lvl_q[ABW-1:0];
    b       = cmd_q.address[bidx];
    nx      = b ? c1 : c0;
    wb_nx   = b ? wb_q[W-1:CW+IW+1] : wb_q[CW+IW:CW+1];
    at_end  = lvl_q == cmd_q.prefix_len;
    need    = cmd_q.prefix_len - lvl_q;
  end

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    cur_d      = cur_q;
    par_d      = par_q;
    best_d     = best_q;
    clr_d      = clr_q;
    lvl_d      = lvl_q;
    bestlen_d  = bestlen_q;
    pass2_d    = pass2_q;
    fresh_d    = fresh_q;
    found_d    = found_q;
    pb_d       = pb_q;
    wb_d       = wb_q;
    parw_d     = parw_q;
    top_d      = top_q;
    res_st_d   = res_st_q;
    res_gw_d   = res_gw_q;
    res_len_d  = res_len_q;
    ov_d       = ov_q && out_stall_i;
    ost_d      = ost_q;
    ogw_d      = ogw_q;
    olen_d     = olen_q;
    new_cnt    = cnt;
    nw         = word;
    pop_o      = 1'b0;
    node_we    = 1'b0;
    node_waddr = cur_q;
    node_wdata = '0;
    node_raddr = cur_q;
    stk_we     = 1'b0;
    stk_waddr  = clr_q;
    stk_wdata  = '0;
    stk_raddr  = IW'(top_q - CW'(1));
    gw_we      = 1'b0;
    gw_waddr   = cur_q;
    gw_raddr   = best_q;

    case (state_q)
      S_CLEAR: begin
        node_we    = 1'b1;
        node_waddr = clr_q;
        node_wdata = (clr_q == '0) ? W'(1) : '0;   // root starts with count one
        stk_we     = 1'b1;
        stk_waddr  = clr_q;
        stk_wdata  = IW'(NODES - 1) - clr_q;
        clr_d      = clr_q + IW'(1);
        if (clr_q == IW'(NODES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (queue_i.valid) begin
          pop_o     = 1'b1;
          cmd_d     = queue_i.cmd;
          cur_d     = '0;
          lvl_d     = '0;
          pass2_d   = 1'b0;
          fresh_d   = 1'b0;
          found_d   = 1'b0;
          best_d    = '0;
          bestlen_d = '0;
          res_gw_d  = '0;
          res_len_d = '0;
          if (queue_i.cmd.kind == CMD_REJECT) begin
            res_st_d = STAT_REJECT;
            state_d  = S_DONE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_EX;
      end
      S_EX: begin
        case (cmd_q.kind)
          CMD_LOOKUP: begin
            if (lvl_q != '0 && mk) begin
              best_d    = cur_q;
              bestlen_d = lvl_q;
              found_d   = 1'b1;
            end
            gw_raddr = best_d;
            if (lvl_q == LEN_W'(ADDR_BITS) || nx == '0) begin
              if (found_d) begin
                state_d = S_GW;
              end else begin
                res_st_d = STAT_NOTFOUND;
                state_d  = S_DONE;
              end
            end else begin
              cur_d   = nx;
              lvl_d   = lvl_q + LEN_W'(1);
              state_d = S_RD;
            end
          end
          CMD_INSERT: begin
            if (!pass2_q) begin
              if (at_end && mk) begin
                gw_we    = 1'b1;
                res_st_d = STAT_OK;
                state_d  = S_DONE;
              end else if (at_end || nx == '0) begin
                if (CW'(need) > top_q) begin
                  res_st_d = STAT_FULL;
                  state_d  = S_DONE;
                end else begin
                  pass2_d = 1'b1;
                  cur_d   = '0;
                  lvl_d   = '0;
                  state_d = S_RD;
                end
              end else begin
                cur_d   = nx;
                lvl_d   = lvl_q + LEN_W'(1);
                state_d = S_RD;
              end
            end else begin
              nw          = word;
              nw[CW-1:0]  = cnt + CW'(1);
              if (at_end) begin
                nw[CW]     = 1'b1;
                node_we    = 1'b1;
                node_wdata = nw;
                gw_we      = 1'b1;
                res_st_d   = STAT_OK;
                state_d    = S_DONE;
              end else if (nx == '0) begin
                wb_d    = nw;
                state_d = S_POP;
              end else begin
                node_we    = 1'b1;
                node_wdata = nw;
                cur_d      = nx;
                lvl_d      = lvl_q + LEN_W'(1);
                fresh_d    = 1'b0;
                state_d    = S_RD;
              end
            end
          end
          CMD_DELETE: begin
            if (!pass2_q) begin
              if (at_end) begin
                if (mk) begin
                  pass2_d = 1'b1;
                  cur_d   = '0;
                  lvl_d   = '0;
                  state_d = S_RD;
                end else begin
                  res_st_d = STAT_NOTFOUND;
                  state_d  = S_DONE;
                end
              end else if (nx == '0) begin
                res_st_d = STAT_NOTFOUND;
                state_d  = S_DONE;
              end else begin
                cur_d   = nx;
                lvl_d   = lvl_q + LEN_W'(1);
                state_d = S_RD;
              end
            end else begin
              new_cnt    = (cnt != '0) ? cnt - CW'(1) : cnt;
              nw         = word;
              nw[CW-1:0] = new_cnt;
              if (at_end) begin
                nw[CW] = 1'b0;
              end
              node_we    = 1'b1;
              node_wdata = nw;
              if (lvl_q != '0 && new_cnt == '0) begin
                // node no longer on any route: unlink from parent and free it
                wb_d    = nw;
                state_d = S_FREE;
              end else begin
                par_d  = cur_q;
                parw_d = nw;
                pb_d   = b;
                if (at_end || nx == '0) begin
                  res_st_d = STAT_OK;
                  state_d  = S_DONE;
                end else begin
                  cur_d   = nx;
                  lvl_d   = lvl_q + LEN_W'(1);
                  state_d = S_RD;
                end
              end
            end
          end
          default: begin
            res_st_d = STAT_REJECT;
            state_d  = S_DONE;
          end
        endcase
      end
      S_POP: begin
        state_d = S_POPW;
      end
      S_POPW: begin
        node_we    = 1'b1;
        node_wdata = wb_q;
        if (b) begin
          node_wdata[W-1:CW+IW+1] = stk_rd_q;
        end else begin
          node_wdata[CW+IW:CW+1] = stk_rd_q;
        end
        top_d   = top_q - CW'(1);
        cur_d   = stk_rd_q;
        lvl_d   = lvl_q + LEN_W'(1);
        fresh_d = 1'b1;
        state_d = S_RD;
      end
      S_FREE: begin
        node_we    = 1'b1;
        node_waddr = par_q;
        node_wdata = parw_q;
        if (pb_q) begin
          node_wdata[W-1:CW+IW+1] = '0;
        end else begin
          node_wdata[CW+IW:CW+1] = '0;
        end
        if (top_q < CW'(NODES)) begin
          stk_we    = 1'b1;
          stk_waddr = top_q[IW-1:0];
          stk_wdata = cur_q;
          top_d     = top_q + CW'(1);
        end
        par_d  = cur_q;
        parw_d = wb_q;
        pb_d   = b;
        if (at_end || wb_nx == '0) begin
          res_st_d = STAT_OK;
          state_d  = S_DONE;
        end else begin
          cur_d   = wb_nx;
          lvl_d   = lvl_q + LEN_W'(1);
          state_d = S_RD;
        end
      end
      S_GW: begin
        res_st_d  = STAT_OK;
        res_gw_d  = gw_rd_q;
        res_len_d = bestlen_q;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!ov_q || !out_stall_i) begin
          ov_d    = 1'b1;
          ost_d   = res_st_q;
          ogw_d   = res_gw_q;
          olen_d  = res_len_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      top_q   <= CW'(NODES - 1);
      ov_q    <= 1'b0;
      pass2_q <= 1'b0;
      fresh_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      top_q   <= top_d;
      ov_q    <= ov_d;
      pass2_q <= pass2_d;
      fresh_q <= fresh_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    cur_q     <= cur_d;
    par_q     <= par_d;
    best_q    <= best_d;
    lvl_q     <= lvl_d;
    bestlen_q <= bestlen_d;
    pb_q      <= pb_d;
    wb_q      <= wb_d;
    parw_q    <= parw_d;
    res_st_q  <= res_st_d;
    res_gw_q  <= res_gw_d;
    res_len_q <= res_len_d;
    ost_q     <= ost_d;
    ogw_q     <= ogw_d;
    olen_q    <= olen_d;
  end

  assign out_valid_o   = ov_q;
  assign status_o      = ost_q;
  assign gateway_out_o = ogw_q;
  assign match_len_o   = olen_q;

endmodule
